/* rtl/rlpm_pkg.sv */
`timescale 1ns / 1ps
// rlpm_pkg: shared types and constants for the longest prefix match router
// no dependencies; used by the interfaces, the cell and the top level

package rlpm_pkg;

    localparam int unsigned SLOT_W = 5;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] wr_slot;
        logic              wr_valid;
        logic [ADDR_W-1:0] wr_prefix;
        logic [ADDR_W-1:0] wr_mask;
        logic [ADDR_W-1:0] wr_gateway;
        logic [PORT_W-1:0] wr_port;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [ADDR_W-1:0] best_mask;
        logic [SLOT_W-1:0] best_slot;
        logic [ADDR_W-1:0] best_gateway;
        logic [PORT_W-1:0] best_port;
    } item_t;

endpackage

/* rtl/rlpm_cmd_if.sv */
`timescale 1ns / 1ps
// rlpm_cmd_if: command channel carrying table writes and lookups
// depends on rlpm_pkg

interface rlpm_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [rlpm_pkg::SLOT_W-1:0] slot_index;
    logic                        slot_valid;
    logic [rlpm_pkg::ADDR_W-1:0] route_prefix_in;
    logic [rlpm_pkg::ADDR_W-1:0] route_mask_in;
    logic [rlpm_pkg::ADDR_W-1:0] gateway_in;
    logic [rlpm_pkg::PORT_W-1:0] port_in;
    logic [rlpm_pkg::ADDR_W-1:0] lookup_address;

    modport source (
        output valid, operation, slot_index, slot_valid, route_prefix_in,
               route_mask_in, gateway_in, port_in, lookup_address,
        input  ready
    );

    modport sink (
        input  valid, operation, slot_index, slot_valid, route_prefix_in,
               route_mask_in, gateway_in, port_in, lookup_address,
        output ready
    );
endinterface

/* rtl/rlpm_rsp_if.sv */
`timescale 1ns / 1ps
// rlpm_rsp_if: response channel carrying lookup results
// depends on rlpm_pkg

interface rlpm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [rlpm_pkg::SLOT_W-1:0] matched_slot;
    logic [rlpm_pkg::ADDR_W-1:0] next_hop;
    logic [rlpm_pkg::PORT_W-1:0] out_port;

    modport source (
        output valid, hit, matched_slot, next_hop, out_port,
        input  ready
    );

    modport sink (
        input  valid, hit, matched_slot, next_hop, out_port,
        output ready
    );
endinterface

/* rtl/rlpm_cell.sv */
`timescale 1ns / 1ps
// rlpm_cell: one route slot of the chain; applies writes aimed at it and
// folds its entry into the best match of a passing lookup; depends on rlpm_pkg

module rlpm_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            up_live,
    input  rlpm_pkg::item_t up_item,
    output logic            dn_live,
    output rlpm_pkg::item_t dn_item
);

    localparam bit IN_RANGE = (INDEX < (2 ** rlpm_pkg::SLOT_W));
    localparam int unsigned INDEX_I = INDEX;
    localparam logic [rlpm_pkg::SLOT_W-1:0] SLOT_ID = INDEX_I[rlpm_pkg::SLOT_W-1:0];

    logic                        ent_valid_reg;
    logic [rlpm_pkg::ADDR_W-1:0] ent_prefix_reg;
    logic [rlpm_pkg::ADDR_W-1:0] ent_mask_reg;
    logic [rlpm_pkg::ADDR_W-1:0] ent_gateway_reg;
    logic [rlpm_pkg::PORT_W-1:0] ent_port_reg;

    logic            live_reg;
    rlpm_pkg::item_t item_reg;
    rlpm_pkg::item_t item_next;

    logic wr_hit;
    logic match;
    logic take;

    assign wr_hit = up_live && (up_item.op == rlpm_pkg::OP_WRITE) && IN_RANGE
                    && (up_item.wr_slot == SLOT_ID);

    assign match = ent_valid_reg
                   && (((ent_prefix_reg ^ up_item.addr) & ent_mask_reg) == '0);
    assign take  = (up_item.op == rlpm_pkg::OP_LOOKUP) && match
                   && (!up_item.found || (ent_mask_reg >= up_item.best_mask));

    always_comb
    begin
        item_next = up_item;
        if (take)
        begin
            item_next.found        = 1'b1;
            item_next.best_mask    = ent_mask_reg;
            item_next.best_slot    = SLOT_ID;
            item_next.best_gateway = ent_gateway_reg;
            item_next.best_port    = ent_port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            live_reg      <= 1'b0;
        end
        else if (advance)
        begin
            live_reg <= up_live;
            if (wr_hit)
            begin
                ent_valid_reg <= up_item.wr_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
            if (wr_hit)
            begin
                ent_prefix_reg  <= up_item.wr_prefix;
                ent_mask_reg    <= up_item.wr_mask;
                ent_gateway_reg <= up_item.wr_gateway;
                ent_port_reg    <= up_item.wr_port;
            end
        end
    end

    assign dn_live = live_reg;
    assign dn_item = item_reg;

endmodule

/* rtl/route_longest_prefix_match.sv */
`timescale 1ns / 1ps
// Longest prefix match IPv4 route table built as a chain of ENTRIES cells,
// one route slot per cell. Every command transaction, table write or lookup,
// enters the chain and moves one cell per cycle while nothing stalls it, so
// a new transaction is accepted every cycle when not stalled and a lookup
// sees exactly the writes accepted before it. A lookup result passes through
// the ENTRIES cell registers in order and then the output register; writes
// produce no response. The whole chain stalls only while the output register
// holds a result the consumer has not taken. Among valid matching slots the
// largest mask wins and ties go to the highest slot; a miss returns all-zero
// fields. Slot valid marks clear on reset, with no clearing pass.
// depends on rlpm_pkg, rlpm_cmd_if, rlpm_rsp_if and rlpm_cell

module route_longest_prefix_match #(
    parameter int unsigned ENTRIES = 32,
    parameter int unsigned PORTS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rlpm_cmd_if.sink    cmd,
    rlpm_rsp_if.source  rsp
);

    localparam int unsigned PORT_LIM =
        (PORTS > (2 ** rlpm_pkg::PORT_W)) ? (2 ** rlpm_pkg::PORT_W) : PORTS;
    localparam int unsigned PORT_MAX_I = PORT_LIM - 1;
    localparam logic [rlpm_pkg::PORT_W-1:0] PORT_MAX =
        PORT_MAX_I[rlpm_pkg::PORT_W-1:0];

    logic            advance;
    logic            live_chain [ENTRIES+1];
    rlpm_pkg::item_t item_chain [ENTRIES+1];
    rlpm_pkg::item_t head_item;

    logic                        rsp_valid_reg;
    logic                        rsp_hit_reg;
    logic [rlpm_pkg::SLOT_W-1:0] rsp_slot_reg;
    logic [rlpm_pkg::ADDR_W-1:0] rsp_hop_reg;
    logic [rlpm_pkg::PORT_W-1:0] rsp_port_reg;
    logic                        rsp_valid_next;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = advance;

    // transaction entering the chain, with an empty best match
    always_comb
    begin
        head_item.op           = cmd.operation;
        head_item.wr_slot      = cmd.slot_index;
        head_item.wr_valid     = cmd.slot_valid;
        head_item.wr_prefix    = cmd.route_prefix_in;
        head_item.wr_mask      = cmd.route_mask_in;
        head_item.wr_gateway   = cmd.gateway_in;
        head_item.wr_port      = (32'(cmd.port_in) >= PORTS) ? PORT_MAX : cmd.port_in;
        head_item.addr         = cmd.lookup_address;
        head_item.found        = 1'b0;
        head_item.best_mask    = '0;
        head_item.best_slot    = '0;
        head_item.best_gateway = '0;
        head_item.best_port    = '0;
    end

    assign live_chain[0] = cmd.valid;
    assign item_chain[0] = head_item;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rlpm_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .up_live (live_chain[i]),
            .up_item (item_chain[i]),
            .dn_live (live_chain[i+1]),
            .dn_item (item_chain[i+1])
        );
    end

    assign rsp_valid_next = live_chain[ENTRIES]
                            && (item_chain[ENTRIES].op == rlpm_pkg::OP_LOOKUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rsp_valid_next)
        begin
            rsp_hit_reg  <= item_chain[ENTRIES].found;
            rsp_slot_reg <= item_chain[ENTRIES].best_slot;
            rsp_hop_reg  <= item_chain[ENTRIES].best_gateway;
            rsp_port_reg <= item_chain[ENTRIES].best_port;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = rsp_hit_reg;
    assign rsp.matched_slot = rsp_slot_reg;
    assign rsp.next_hop     = rsp_hop_reg;
    assign rsp.out_port     = rsp_port_reg;

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.hit |->
            (rsp.matched_slot == '0) && (rsp.next_hop == '0) && (rsp.out_port == '0))
        else $error("miss response with nonzero fields");

    // a hit names a slot that exists
    a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> (32'(rsp.matched_slot) < ENTRIES))
        else $error("hit names a slot beyond the table");

    // a held response freezes the chain and blocks new commands
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !cmd.ready ##1 $stable(live_chain[ENTRIES]))
        else $error("chain moved while the response was stalled");

    // a lookup leaving the chain becomes a response in the next cycle
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rsp_valid_next |=> rsp.valid)
        else $error("lookup result lost at the chain output");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for route_longest_prefix_match, with a route
// predictor, random idling on both channels and a long output stall
// depends on rlpm_pkg, rlpm_cmd_if, rlpm_rsp_if and the route table rtl

module testbench;

    localparam int unsigned SLOT_W     = rlpm_pkg::SLOT_W;
    localparam int unsigned ADDR_W     = rlpm_pkg::ADDR_W;
    localparam int unsigned PORT_W     = rlpm_pkg::PORT_W;
    localparam int unsigned ENTRIES    = 32;
    localparam int unsigned PORTS      = 8;
    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned SETTLE     = ENTRIES + 8;
    localparam int unsigned POOL_SIZE  = 6;

    typedef struct {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic              slot_valid;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
    } route_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] next_hop;
        logic [PORT_W-1:0] port;
    } route_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rlpm_cmd_if cmd_ch ();
    rlpm_rsp_if rsp_ch ();

    route_longest_prefix_match #(
        .ENTRIES (ENTRIES),
        .PORTS   (PORTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic              tbl_valid   [ENTRIES];
    logic [ADDR_W-1:0] tbl_prefix  [ENTRIES];
    logic [ADDR_W-1:0] tbl_mask    [ENTRIES];
    logic [ADDR_W-1:0] tbl_gateway [ENTRIES];
    logic [PORT_W-1:0] tbl_port    [ENTRIES];
    logic [ADDR_W-1:0] net_pool    [POOL_SIZE];

    route_result_t expected_routes [$];
    int unsigned   mismatches;
    logic          sender_burst;
    logic          recv_free;
    logic          hold_request;
    int unsigned   hold_cycles;

    // route predictor
    function automatic route_result_t predict_route(input logic [ADDR_W-1:0] addr);
        route_result_t     r;
        logic [ADDR_W-1:0] best_mask;
        r = '0;
        best_mask = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && ((tbl_prefix[i] & tbl_mask[i]) == (addr & tbl_mask[i]))
                && (!r.hit || tbl_mask[i] >= best_mask))
            begin
                r.hit      = 1'b1;
                best_mask  = tbl_mask[i];
                r.slot     = SLOT_W'(i);
                r.next_hop = tbl_gateway[i];
                r.port     = tbl_port[i];
            end
        end
        return r;
    endfunction

    function automatic void store_route(input route_cmd_t c);
        if (c.slot < ENTRIES)
        begin
            tbl_valid[c.slot]   = c.slot_valid;
            tbl_prefix[c.slot]  = c.prefix;
            tbl_mask[c.slot]    = c.mask;
            tbl_gateway[c.slot] = c.gateway;
            tbl_port[c.slot]    = (c.port >= PORTS) ? PORT_W'(PORTS - 1) : c.port;
        end
    endfunction

    function automatic route_cmd_t make_write(input int slot, input logic slot_valid,
                                              input logic [ADDR_W-1:0] prefix,
                                              input logic [ADDR_W-1:0] mask,
                                              input logic [ADDR_W-1:0] gateway,
                                              input int port);
        route_cmd_t c;
        c.op         = rlpm_pkg::OP_WRITE;
        c.slot       = SLOT_W'(slot);
        c.slot_valid = slot_valid;
        c.prefix     = prefix;
        c.mask       = mask;
        c.gateway    = gateway;
        c.port       = PORT_W'(port);
        c.addr       = $urandom;
        return c;
    endfunction

    function automatic route_cmd_t make_lookup(input logic [ADDR_W-1:0] addr);
        route_cmd_t c;
        c.op         = rlpm_pkg::OP_LOOKUP;
        c.slot       = SLOT_W'($urandom_range(0, 31));
        c.slot_valid = 1'($urandom_range(0, 1));
        c.prefix     = $urandom;
        c.mask       = $urandom;
        c.gateway    = $urandom;
        c.port       = PORT_W'($urandom_range(0, 7));
        c.addr       = addr;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
        logic [ADDR_W-1:0] m;
        m = '1;
        return (len == 0) ? '0 : m << (ADDR_W - len);
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        if (sender_burst || $urandom_range(0, 99) < 60)
            return 0;
        return idle_length();
    endfunction

    // address inside a live route, or anything at all
    function automatic logic [ADDR_W-1:0] pick_route_address();
        int s;
        for (int t = 0; t < 8; t++)
        begin
            s = $urandom_range(0, ENTRIES - 1);
            if (tbl_valid[s])
                return (tbl_prefix[s] & tbl_mask[s]) | ($urandom & ~tbl_mask[s]);
        end
        return $urandom;
    endfunction

    function automatic route_cmd_t random_write();
        logic [ADDR_W-1:0] m;
        if ($urandom_range(0, 19) == 0)
            m = $urandom;
        else
        begin
            case ($urandom_range(0, 5))
                0: m = prefix_mask(0);
                1: m = prefix_mask(8);
                2: m = prefix_mask(16);
                3: m = prefix_mask(24);
                4: m = prefix_mask(32);
                default: m = prefix_mask($urandom_range(0, 32));
            endcase
        end
        return make_write($urandom_range(0, 31), $urandom_range(0, 9) != 0,
                          (net_pool[$urandom_range(0, POOL_SIZE - 1)] & m) | ($urandom & ~m),
                          m, $urandom, $urandom_range(0, 7));
    endfunction

    function automatic void compare_field(input string name, input logic [ADDR_W-1:0] want,
                                          input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // one command transaction; called and returns at a falling edge
    task automatic send_command(input route_cmd_t c, input int gap);
        cmd_ch.valid           <= 1'b1;
        cmd_ch.operation       <= c.op;
        cmd_ch.slot_index      <= c.slot;
        cmd_ch.slot_valid      <= c.slot_valid;
        cmd_ch.route_prefix_in <= c.prefix;
        cmd_ch.route_mask_in   <= c.mask;
        cmd_ch.gateway_in      <= c.gateway;
        cmd_ch.port_in         <= c.port;
        cmd_ch.lookup_address  <= c.addr;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (c.op == rlpm_pkg::OP_LOOKUP)
            expected_routes.push_back(predict_route(c.addr));
        else
            store_route(c);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (expected_routes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic test_empty_table();
        send_command(make_lookup(32'h0000_0000), next_gap());
        send_command(make_lookup(32'hFFFF_FFFF), next_gap());
        drain_results();
    endtask

    task automatic test_route_precedence();
        send_command(make_write(0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 0),
                     next_gap());
        send_command(make_write(31, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 7),
                     next_gap());
        send_command(make_write(5, 1'b1, 32'h0A0B_1234, 32'hFFFF_0000, 32'h0A0B_0001, 3),
                     next_gap());
        send_command(make_write(20, 1'b1, 32'h0A0B_0C00, 32'hFFFF_FF00, 32'h0A0B_0C01, 4),
                     next_gap());
        send_command(make_write(3, 1'b1, 32'h0A0B_0CFF, 32'hFFFF_FF00, 32'h0A0B_0C02, 5),
                     next_gap());
        send_command(make_write(10, 1'b1, 32'h0A0B_0C0D, 32'hFFFF_FFFF, 32'h0000_0000, 6),
                     next_gap());
        send_command(make_write(12, 1'b1, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'h5555_AAAA, 1),
                     next_gap());
        send_command(make_lookup(32'h0A0B_0C0D), next_gap());
        send_command(make_lookup(32'h0A0B_0C0E), next_gap());
        send_command(make_lookup(32'h0A0B_0D01), next_gap());
        send_command(make_lookup(32'h0A7F_0000), next_gap());
        send_command(make_lookup(32'hC000_0001), next_gap());
        send_command(make_lookup(32'h0F0F_0F0F), next_gap());
        send_command(make_lookup(32'hFFFF_FFFF), next_gap());
        // removed slots drop out of the match
        send_command(make_write(10, 1'b0, $urandom, $urandom, $urandom, 2), next_gap());
        send_command(make_lookup(32'h0A0B_0C0D), next_gap());
        send_command(make_write(0, 1'b0, $urandom, $urandom, $urandom, 0), next_gap());
        send_command(make_lookup(32'hC000_0001), next_gap());
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] a;
        for (int p = 0; p < POOL_SIZE; p++)
            net_pool[p] = $urandom;
        net_pool[0] = 32'h0000_0000;
        net_pool[1] = 32'hFFFF_FFFF;
        for (int chunk = 0; chunk < 11; chunk++)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            recv_free    = ($urandom_range(0, 3) == 0);
            if (chunk == 5)
                drain_results();
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_command(random_write(), next_gap());
                else
                begin
                    case ($urandom_range(0, 3))
                        0: a = $urandom;
                        1: a = net_pool[$urandom_range(0, POOL_SIZE - 1)] ^ ($urandom >> 16);
                        default: a = pick_route_address();
                    endcase
                    send_command(make_lookup(a), next_gap());
                end
            end
        end
        sender_burst = 1'b0;
        recv_free    = 1'b0;
        drain_results();
    endtask

    // receiver holds off while lookups pile up behind the full chain
    task automatic test_output_stall();
        hold_cycles  = 300;
        hold_request = 1'b1;
        for (int n = 0; n < 80; n++)
            send_command(make_lookup(pick_route_address()), 0);
        drain_results();
    endtask

    initial
    begin : result_receiver
        int   run_left;
        logic ready_state;
        rsp_ch.ready = 1'b0;
        run_left     = 0;
        ready_state  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_request = 1'b0;
                run_left     = 0;
                ready_state  = 1'b0;
            end
            else if (recv_free)
                rsp_ch.ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    ready_state = !ready_state;
                    run_left    = ready_state ? $urandom_range(1, 30) : idle_length();
                end
                rsp_ch.ready <= ready_state;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        route_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_routes.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none actual hit %0b slot %0d",
                         $time, rsp_ch.hit, rsp_ch.matched_slot);
                mismatches++;
            end
            else
            begin
                want = expected_routes.pop_front();
                compare_field("hit", ADDR_W'(want.hit), ADDR_W'(rsp_ch.hit));
                compare_field("matched_slot", ADDR_W'(want.slot),
                              ADDR_W'(rsp_ch.matched_slot));
                compare_field("next_hop", want.next_hop, rsp_ch.next_hop);
                compare_field("out_port", ADDR_W'(want.port), ADDR_W'(rsp_ch.out_port));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int unsigned idle_cycles;
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.operation       = rlpm_pkg::OP_WRITE;
        cmd_ch.slot_index      = '0;
        cmd_ch.slot_valid      = 1'b0;
        cmd_ch.route_prefix_in = '0;
        cmd_ch.route_mask_in   = '0;
        cmd_ch.gateway_in      = '0;
        cmd_ch.port_in         = '0;
        cmd_ch.lookup_address  = '0;
        mismatches             = 0;
        sender_burst           = 1'b0;
        recv_free              = 1'b0;
        hold_request           = 1'b0;
        hold_cycles            = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i]   = 1'b0;
            tbl_prefix[i]  = '0;
            tbl_mask[i]    = '0;
            tbl_gateway[i] = '0;
            tbl_port[i]    = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_table();
        test_route_precedence();
        test_random_traffic();
        test_output_stall();
        if (mismatches == 0 && expected_routes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
